// File: design/imhq_pkg.sv
`timescale 1ns / 1ps
package imhq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE,
    S_OUT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // clear one presence entry
    logic load;      // capture input word
    logic start;     // decode item, first writes
    logic up_rd;     // read parent for sift up
    logic up_cmp;    // compare and swap with parent
    logic dn_rd;     // read both children
    logic dn_cmp;    // compare and swap with child
    logic finish;    // register result word
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;  // last presence entry being cleared
    logic go_up;     // start went to sift up
    logic go_dn;     // start went to sift down
    logic up_more;   // sift up continues
    logic dn_more;   // sift down continues
  } dp_sts_t;

endpackage

// File: design/imhq_in_if.sv
`timescale 1ns / 1ps
interface imhq_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [9:0]  node_id;
  logic [31:0] cost;
  modport source (output valid, func, node_id, cost, input ready);
  modport sink (input valid, func, node_id, cost, output ready);
endinterface

// File: design/imhq_out_if.sv
`timescale 1ns / 1ps
interface imhq_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  popped_node;
  logic [31:0] popped_cost;
  logic [1:0]  status;
  logic [10:0] count;
  modport source (output valid, popped_node, popped_cost, status, count, input ready);
  modport sink (input valid, popped_node, popped_cost, status, count, output ready);
endinterface

// File: design/imhq_ram.sv
`timescale 1ns / 1ps
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/imhq_ctrl.sv
`timescale 1ns / 1ps
module imhq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  imhq_pkg::dp_sts_t sts,
  output imhq_pkg::dp_cmd_t cmd
);
  import imhq_pkg::*;

  fsm_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_START;
      S_START: begin
        priority if (sts.go_up) state_nxt = S_UP_RD;
        else if (sts.go_dn) state_nxt = S_DN_RD;
        else state_nxt = S_DONE;
      end
      S_UP_RD:  state_nxt = S_UP_CMP;
      S_UP_CMP: state_nxt = sts.up_more ? S_UP_RD : S_DONE;
      S_DN_RD:  state_nxt = S_DN_CMP;
      S_DN_CMP: state_nxt = sts.dn_more ? S_DN_RD : S_DONE;
      S_DONE:   state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.start  = (state_r == S_START);
    cmd.up_rd  = (state_r == S_UP_RD);
    cmd.up_cmp = (state_r == S_UP_CMP);
    cmd.dn_rd  = (state_r == S_DN_RD);
    cmd.dn_cmp = (state_r == S_DN_CMP);
    cmd.finish = (state_r == S_DONE);
    in_ready   = (state_r == S_IDLE);
    out_valid  = (state_r == S_OUT);
  end
endmodule

// File: design/imhq_dp.sv
`timescale 1ns / 1ps
module imhq_dp #(
  parameter int CAPACITY   = 1024,
  parameter int NODE_COUNT = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  imhq_pkg::dp_cmd_t cmd,
  output imhq_pkg::dp_sts_t sts,
  input  logic              in_func,
  input  logic [9:0]        in_node_id,
  input  logic [31:0]       in_cost,
  output logic [9:0]        out_popped_node,
  output logic [31:0]       out_popped_cost,
  output logic [1:0]        out_status,
  output logic [10:0]       out_count
);
  import imhq_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = SW + 2;  // child slot arithmetic
  localparam int VW = NW + KEY_WIDTH;

  // a heap entry is {node, key}; one memory per child parity lets both
  // children (slots 2s+1 odd, 2s+2 even) be read at once
  logic           we_o, we_e, pos_we, pres_we;
  logic [SW-1:0]  wa_o, wa_e, ra_o, ra_e;
  logic [VW-1:0]  wd_o, wd_e, rd_o, rd_e;
  logic [NW-1:0]  pos_wa, pos_ra, pres_wa;
  logic [SW-1:0]  pos_wd, pos_rd;
  logic           pres_wd, pres_rd;

  imhq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_odd (
    .clk, .we(we_o), .waddr(wa_o), .wdata(wd_o), .raddr(ra_o), .rdata(rd_o));
  imhq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_even (
    .clk, .we(we_e), .waddr(wa_e), .wdata(wd_e), .raddr(ra_e), .rdata(rd_e));
  imhq_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_pos (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra),
    .rdata(pos_rd));
  // presence table, read alongside the position table
  imhq_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_pres (
    .clk, .we(pres_we), .waddr(pres_wa), .wdata(pres_wd), .raddr(pos_ra),
    .rdata(pres_rd));

  // count, clearing pointer and pop pending flag
  logic [CW-1:0]         count_r;
  logic [NW-1:0]         clr_r;
  logic                  pend_r;

  // item and walk state
  logic                 func_r;
  logic [9:0]           id_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [SW-1:0]        slot_r;       // current slot of moving entry
  logic [VW-1:0]        ent_r;        // moving entry
  logic [SW-1:0]        last_r;
  logic [9:0]           pnode_r;
  logic [KEY_WIDTH-1:0] pcost_r;
  logic [1:0]           status_r;
  logic [9:0]           o_node_r;
  logic [31:0]          o_cost_r;
  logic [1:0]           o_status_r;
  logic [10:0]          o_count_r;

  logic                 id_ok, pres_id;
  logic [SW-1:0]        last;
  logic [EW-1:0]        l_e, r_e;
  logic [SW-1:0]        up_slot;
  logic [VW-1:0]        par_ent;

  assign id_ok   = ({22'd0, id_r} < 32'(NODE_COUNT));
  assign pres_id = pres_rd;
  assign last    = SW'(count_r - CW'(1));
  assign l_e     = {slot_r, 1'b1};
  assign r_e     = {slot_r, 1'b1} + EW'(1);
  assign up_slot = SW'((slot_r - SW'(1)) >> 1);
  // parent slot p lives in bank p[0] ? odd : even (slot 0 in even bank)
  assign par_ent = up_slot[0] ? rd_o : rd_e;

  logic [KEY_WIDTH-1:0] ek, lk, rk;
  logic                 gl, gr, pick_l;
  assign ek = ent_r[KEY_WIDTH-1:0];
  assign lk = rd_o[KEY_WIDTH-1:0];
  assign rk = rd_e[KEY_WIDTH-1:0];
  assign gl = (l_e < EW'(count_r)) && (ek > lk);
  assign gr = (r_e < EW'(count_r)) && (ek > rk);
  assign pick_l = gl && (!gr || (lk < rk));

  // memory port steering
  always_comb begin
    we_o = 1'b0; we_e = 1'b0; pos_we = 1'b0;
    wa_o = slot_r; wa_e = slot_r; wd_o = ent_r; wd_e = ent_r;
    ra_o = slot_r; ra_e = slot_r;
    pos_wa = ent_r[VW-1:KEY_WIDTH]; pos_wd = slot_r; pos_ra = in_node_id[NW-1:0];
    pres_we = 1'b0; pres_wa = clr_r; pres_wd = 1'b0;
    sts = '0;
    if (cmd.clear) begin
      pres_we = 1'b1;
      sts.clr_done = (clr_r == NW'(NODE_COUNT - 1));
    end
    if (cmd.load) begin
      // fetch root (even bank slot 0) with the node's position and presence
      ra_e   = '0;
      ra_o   = '0;
    end
    if (cmd.up_rd) begin
      ra_o = up_slot;
      ra_e = up_slot;
    end
    if (cmd.dn_rd) begin
      ra_o = SW'(l_e);
      ra_e = SW'(r_e);
    end
    if (cmd.up_cmp) begin
      // parent moves down unless its key is strictly smaller
      if (!(par_ent[KEY_WIDTH-1:0] < ek)) begin
        we_o = slot_r[0]; we_e = ~slot_r[0];
        wd_o = par_ent; wd_e = par_ent;
        pos_we = 1'b1; pos_wa = par_ent[VW-1:KEY_WIDTH]; pos_wd = slot_r;
        sts.up_more = (up_slot != '0);
      end
    end
    if (cmd.dn_cmp && (gl || gr)) begin
      if (slot_r == '0 || !slot_r[0]) begin
        we_e = 1'b1; wd_e = pick_l ? rd_o : rd_e;
      end else begin
        we_o = 1'b1; wd_o = pick_l ? rd_o : rd_e;
      end
      pos_we = 1'b1;
      pos_wa = pick_l ? rd_o[VW-1:KEY_WIDTH] : rd_e[VW-1:KEY_WIDTH];
      pos_wd = slot_r;
      sts.dn_more = 1'b1;
    end
    if (cmd.finish && status_r == ST_OK && (func_r || (id_ok))) begin
      if (!(func_r && count_r == '0)) begin
        we_o = slot_r[0]; we_e = ~slot_r[0];
        pos_we = 1'b1;
      end
    end
    if (cmd.start) begin
      sts.go_up = !func_r && id_ok && (pres_id ? (pos_rd != '0)
                                                : (count_r < CW'(CAPACITY)) && (count_r != '0));
      sts.go_dn = func_r && (count_r > CW'(1));
      // pop needs the last entry: read it now
      ra_o = last; ra_e = last;
      // presence: popped node leaves, new node joins
      if (func_r) begin
        if (count_r != '0) begin
          pres_we = 1'b1;
          pres_wa = rd_e[VW-1:KEY_WIDTH];
        end
      end else if (id_ok && !pres_id && count_r < CW'(CAPACITY)) begin
        pres_we = 1'b1;
        pres_wa = id_r[NW-1:0];
        pres_wd = 1'b1;
      end
    end
  end

  // count, clearing pointer, pending last-entry fetch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + NW'(1);
      end
      pend_r <= cmd.start && func_r && (count_r != '0);
      if (cmd.start) begin
        if (func_r) begin
          if (count_r != '0) begin
            count_r <= count_r - CW'(1);
          end
        end else if (id_ok && !pres_id && count_r < CW'(CAPACITY)) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  // walk registers (payload)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      id_r   <= in_node_id;
      key_r  <= KEY_WIDTH'(in_cost);
    end
    if (cmd.start) begin
      pnode_r  <= '0;
      pcost_r  <= '0;
      status_r <= ST_OK;
      last_r   <= last;
      if (func_r) begin
        if (count_r == '0) begin
          status_r <= ST_EMPTY;
        end else begin
          pnode_r <= rd_e[VW-1:KEY_WIDTH];
          pcost_r <= rd_e[KEY_WIDTH-1:0];
          slot_r  <= '0;
        end
      end else begin
        ent_r <= {id_r[NW-1:0], key_r};
        if (id_ok && pres_id) begin
          slot_r <= pos_rd;
        end else if (id_ok && count_r < CW'(CAPACITY)) begin
          slot_r <= SW'(count_r);
        end else if (id_ok) begin
          status_r <= ST_FULL;
        end
      end
    end
    // pop: last entry arrives in the cycle after start, from the bank of its slot
    if (pend_r) begin
      ent_r <= last_r[0] ? rd_o : rd_e;
    end
    if (cmd.up_cmp && !(par_ent[KEY_WIDTH-1:0] < ek)) begin
      slot_r <= up_slot;
    end
    if (cmd.dn_cmp && (gl || gr)) begin
      slot_r <= pick_l ? SW'(l_e) : SW'(r_e);
    end
    if (cmd.finish) begin
      o_node_r   <= 10'(pnode_r);
      o_cost_r   <= 32'(pcost_r);
      o_status_r <= status_r;
      o_count_r  <= 11'(count_r);
    end
  end

  assign out_popped_node = o_node_r;
  assign out_popped_cost = o_cost_r;
  assign out_status      = o_status_r;
  assign out_count       = o_count_r;
endmodule

// File: design/indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// Indexed min-heap priority queue of node identifiers keyed by cost.
// Input channel in_: func 0 inserts node_id with cost, or rewrites the
// cost of a queued node and sifts it up; func 1 pops the minimum.
// Result channel out_: one word per input word with popped node and cost
// (zero unless a pop succeeds), status (ok, pop on empty, insert into
// full) and the entry count afterwards.
// One item at a time: a new input word is taken only after the result word
// for the last one has been accepted. The walk stops at the first compare
// that does not swap, or at the root or a leaf; at most log2(CAPACITY)
// levels are compared. Each level is a registered read of the heap memories,
// then a compare and swap write. Children of a slot sit in separate odd and
// even banks and are read together.
// After reset the presence table is cleared one entry a cycle, and in_ready
// stays low until every entry is cleared; heap and position memories need no
// clearing. A stalled receiver holds the result word and blocks new input
// words.
module indexed_min_heap_queue #(
  parameter int CAPACITY   = 1024,
  parameter int NODE_COUNT = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input logic clk,
  input logic rst_n,
  imhq_in_if.sink    in_ch,
  imhq_out_if.source out_ch
);
  import imhq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  imhq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd);

  imhq_dp #(.CAPACITY(CAPACITY), .NODE_COUNT(NODE_COUNT), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_func(in_ch.func), .in_node_id(in_ch.node_id), .in_cost(in_ch.cost),
    .out_popped_node(out_ch.popped_node), .out_popped_cost(out_ch.popped_cost),
    .out_status(out_ch.status), .out_count(out_ch.count));
endmodule

// File: sim/indexed_min_heap_queue_test.sv
`timescale 1ns / 1ps
module indexed_min_heap_queue_test;
  import imhq_pkg::*;

  localparam int CAP = 1024;
  localparam int NODES = 1024;
  localparam int FN_UPDATE = 0;
  localparam int FN_POP = 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        func;
    logic [9:0]  node_id;
    logic [31:0] cost;
  } heap_req_t;

  typedef struct packed {
    logic [9:0]  popped_node;
    logic [31:0] popped_cost;
    status_t     status;
    logic [10:0] count;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imhq_in_if  in_ch ();
  imhq_out_if out_ch ();

  indexed_min_heap_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [9:0]  hp_node [CAP];
  logic [31:0] hp_key [CAP];
  logic [9:0]  pos_of [NODES];
  bit          queued [NODES];
  int          n_queued;

  heap_req_t pending_words[$];
  heap_res_t expected_words[$];
  int errors = 0;
  int n_pops = 0, n_empty = 0, n_full = 0, n_results = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  function automatic void swap_slots(int a, int b);
    logic [9:0]  tn;
    logic [31:0] tk;
    tn = hp_node[a]; tk = hp_key[a];
    hp_node[a] = hp_node[b]; hp_key[a] = hp_key[b];
    hp_node[b] = tn; hp_key[b] = tk;
    pos_of[hp_node[a]] = 10'(a);
    pos_of[hp_node[b]] = 10'(b);
  endfunction

  function automatic void bubble_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (hp_key[p] < hp_key[s]) break;
      swap_slots(s, p);
      s = p;
    end
  endfunction

  function automatic void bubble_down(int s);
    int l, r, nx;
    bit gl, gr;
    forever begin
      l = 2 * s + 1;
      r = 2 * s + 2;
      gl = l < n_queued && hp_key[s] > hp_key[l];
      gr = r < n_queued && hp_key[s] > hp_key[r];
      if (!gl && !gr) break;
      if (gl && !gr) nx = l;
      else if (!gl && gr) nx = r;
      else nx = (hp_key[l] < hp_key[r]) ? l : r;
      swap_slots(s, nx);
      s = nx;
    end
  endfunction

  function automatic heap_res_t predict_queue(heap_req_t w);
    heap_res_t r;
    int id;
    r = '0;
    r.status = ST_OK;
    id = int'(w.node_id);
    if (w.func == FN_POP) begin
      if (n_queued == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_node = hp_node[0];
        r.popped_cost = hp_key[0];
        n_queued--;
        swap_slots(0, n_queued);
        queued[r.popped_node] = 1'b0;
        bubble_down(0);
      end
    end else if (queued[id]) begin
      hp_key[pos_of[id]] = w.cost;
      bubble_up(pos_of[id]);
    end else if (n_queued >= CAP) begin
      r.status = ST_FULL;
    end else begin
      hp_node[n_queued] = 10'(id);
      hp_key[n_queued] = w.cost;
      pos_of[id] = 10'(n_queued);
      queued[id] = 1'b1;
      n_queued++;
      bubble_up(n_queued - 1);
    end
    r.count = 11'(n_queued);
    return r;
  endfunction

  function automatic heap_req_t mk_word(bit f, int id, logic [31:0] c);
    heap_req_t w;
    w.func = f; w.node_id = 10'(id); w.cost = c;
    return w;
  endfunction

  // driver: one word in flight on the bus at a time
  heap_req_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= 1'b0;
      in_ch.node_id <= '0;
      in_ch.cost <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_words.push_back(predict_queue(cur));
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        cur = pending_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= cur.func;
        in_ch.node_id <= cur.node_id;
        in_ch.cost <= cur.cost;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stalls
  heap_res_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.popped_node, out_ch.popped_cost, out_ch.status, out_ch.count};
        n_results++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, got);
        end else begin
          want = expected_words.pop_front();
          if (got.status == ST_EMPTY) n_empty++;
          if (got.status == ST_FULL) n_full++;
          if (got.status == ST_OK && got.popped_node != 0) n_pops++;
          if (got.popped_node !== want.popped_node) begin
            errors++;
            $display("%0t: popped_node exp %0d got %0d", $time, want.popped_node,
                     got.popped_node);
          end
          if (got.popped_cost !== want.popped_cost) begin
            errors++;
            $display("%0t: popped_cost exp %h got %h", $time, want.popped_cost,
                     got.popped_cost);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // watchdog on cycles without any accepted word
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else if (rst_n && !stim_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rand_cost(int mode);
    case (mode)
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    int i, k, burst, mode;
    n_queued = 0;
    for (i = 0; i < NODES; i++) queued[i] = 1'b0;

    // directed: empty pop, extremes, ties, update upward and downward
    pending_words.push_back(mk_word(FN_POP, 0, 0));
    pending_words.push_back(mk_word(FN_UPDATE, 1023, 32'hFFFF_FFFF));
    pending_words.push_back(mk_word(FN_UPDATE, 0, 32'h0));
    pending_words.push_back(mk_word(FN_UPDATE, 5, 32'd7));
    pending_words.push_back(mk_word(FN_UPDATE, 6, 32'd7));
    pending_words.push_back(mk_word(FN_UPDATE, 7, 32'd7));
    pending_words.push_back(mk_word(FN_UPDATE, 1023, 32'd1));
    pending_words.push_back(mk_word(FN_UPDATE, 6, 32'hFFFF_FFFF));
    pending_words.push_back(mk_word(FN_UPDATE, 682, 32'hAAAA_AAAA));
    pending_words.push_back(mk_word(FN_UPDATE, 341, 32'h5555_5555));
    for (i = 0; i < 11; i++) pending_words.push_back(mk_word(FN_POP, 1023, 32'hFFFF_FFFF));

    // fill to capacity, then an update, pops and random inserts or updates
    for (i = 0; i < CAP; i++) pending_words.push_back(mk_word(FN_UPDATE, i, $urandom));
    pending_words.push_back(mk_word(FN_UPDATE, 17, 32'd3));
    for (i = 0; i < 40; i++) pending_words.push_back(mk_word(FN_POP, 0, 0));
    for (i = 0; i < 40; i++)
      pending_words.push_back(mk_word(FN_UPDATE, $urandom_range(1023), $urandom));

    // random bursts of inserts then pops, with narrow or full key ranges
    k = 0;
    while (k < 700) begin
      burst = $urandom_range(1, 30);
      mode = $urandom_range(2);
      for (i = 0; i < burst; i++) begin
        pending_words.push_back(mk_word(FN_UPDATE,
          (mode == 0) ? $urandom_range(31) : $urandom_range(1023), rand_cost(mode)));
        k++;
      end
      burst = $urandom_range(1, 32);
      for (i = 0; i < burst; i++) begin
        pending_words.push_back(mk_word(FN_POP, $urandom_range(1023), $urandom));
        k++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // stretch with no idling partway through
    wait (pending_words.size() < 900);
    calm = 1'b1;
    wait (pending_words.size() < 600);
    calm = 1'b0;

    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_words.size() == 0);
    stim_done = 1'b1;
    repeat (40) @(posedge clk);
    $display("ran %0d results: %0d pops, %0d empty pops, %0d full inserts", n_results,
             n_pops, n_empty, n_full);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/imhq_pkg.sv
design/imhq_in_if.sv
design/imhq_out_if.sv
design/imhq_ram.sv
design/imhq_ctrl.sv
design/imhq_dp.sv
design/indexed_min_heap_queue.sv
sim/indexed_min_heap_queue_test.sv
